>>> rtl/two_class_priority_queue_unit_assert.svh
// Assertion macros for the two-class priority queue unit.
// Included by the top level; every macro expects clk_i and rst_ni in scope.
`ifndef TWO_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue unit.
// No dependencies; imported by tcpq_ctrl and the top level.
package tcpq_pkg;

  // Fixed field widths of the command and result words
  localparam int unsigned CmdW    = 2;
  localparam int unsigned HandleW = 16;
  localparam int unsigned LevelW  = 5;
  localparam int unsigned StatW   = 2;

  // Default sizing
  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefHandleBits = 16;

  typedef enum logic [CmdW-1:0] {
    CmdEnqLow  = 2'd0,
    CmdEnqHigh = 2'd1,
    CmdDeq     = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  // Outcome of one command, known at acceptance; handle data follows from memory
  typedef struct packed {
    logic                deq_hit;
    logic                from_high;
    status_e             status;
    logic                all_empty;
    logic [LevelW-1:0]   high_level;
    logic [LevelW-1:0]   low_level;
  } step_info_t;

endpackage

>>> rtl/tcpq_ring_mem.sv
// Handle store of one ring: single write port, single read port, registered read.
// Depends on nothing but its parameters.
module tcpq_ring_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcpq_ctrl.sv
// Ring pointers, fill counts and command decode for both priority classes.
// Depends on tcpq_pkg; drives the ports of the two tcpq_ring_mem instances.
module tcpq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = tcpq_pkg::DefQueueDepth,
  parameter int unsigned HANDLE_BITS = tcpq_pkg::DefHandleBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [tcpq_pkg::CmdW-1:0]      command_i,
  input  logic [tcpq_pkg::HandleW-1:0]   item_handle_i,
  // high ring memory
  output logic                           hi_we_o,
  output logic                           hi_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] hi_waddr_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] hi_raddr_o,
  // low ring memory
  output logic                           lo_we_o,
  output logic                           lo_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] lo_waddr_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] lo_raddr_o,
  output logic [HANDLE_BITS-1:0]         wdata_o,
  output tcpq_pkg::step_info_t           info_o
);

  import tcpq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [PtrW-1:0] hi_head_q, hi_head_d, hi_tail_q, hi_tail_d;
  logic [PtrW-1:0] lo_head_q, lo_head_d, lo_tail_q, lo_tail_d;
  logic [CntW-1:0] hi_cnt_q, hi_cnt_d, lo_cnt_q, lo_cnt_d;

  cmd_e cmd;
  logic hi_full, lo_full, hi_empty, lo_empty;
  logic push_hi, push_lo, pop_hi, pop_lo, deq_miss, drop;

  // Command decode
  assign cmd      = cmd_e'(command_i);
  assign hi_full  = (hi_cnt_q == FullCnt);
  assign lo_full  = (lo_cnt_q == FullCnt);
  assign hi_empty = (hi_cnt_q == '0);
  assign lo_empty = (lo_cnt_q == '0);

  assign push_hi  = accept_i && (cmd == CmdEnqHigh) && !hi_full;
  assign push_lo  = accept_i && (cmd == CmdEnqLow)  && !lo_full;
  assign pop_hi   = accept_i && (cmd == CmdDeq) && !hi_empty;
  assign pop_lo   = accept_i && (cmd == CmdDeq) && hi_empty && !lo_empty;
  assign deq_miss = (cmd == CmdDeq) && hi_empty && lo_empty;
  assign drop     = ((cmd == CmdEnqHigh) && hi_full) || ((cmd == CmdEnqLow) && lo_full);

  // Pointer and count update
  always_comb begin
    hi_head_d = hi_head_q;
    hi_tail_d = hi_tail_q;
    hi_cnt_d  = hi_cnt_q;
    lo_head_d = lo_head_q;
    lo_tail_d = lo_tail_q;
    lo_cnt_d  = lo_cnt_q;
    if (push_hi) begin
      hi_tail_d = (hi_tail_q == LastPtr) ? '0 : hi_tail_q + 1'b1;
      hi_cnt_d  = hi_cnt_q + 1'b1;
    end
    if (pop_hi) begin
      hi_head_d = (hi_head_q == LastPtr) ? '0 : hi_head_q + 1'b1;
      hi_cnt_d  = hi_cnt_q - 1'b1;
    end
    if (push_lo) begin
      lo_tail_d = (lo_tail_q == LastPtr) ? '0 : lo_tail_q + 1'b1;
      lo_cnt_d  = lo_cnt_q + 1'b1;
    end
    if (pop_lo) begin
      lo_head_d = (lo_head_q == LastPtr) ? '0 : lo_head_q + 1'b1;
      lo_cnt_d  = lo_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_head_q <= '0;
      hi_tail_q <= '0;
      hi_cnt_q  <= '0;
      lo_head_q <= '0;
      lo_tail_q <= '0;
      lo_cnt_q  <= '0;
    end else begin
      hi_head_q <= hi_head_d;
      hi_tail_q <= hi_tail_d;
      hi_cnt_q  <= hi_cnt_d;
      lo_head_q <= lo_head_d;
      lo_tail_q <= lo_tail_d;
      lo_cnt_q  <= lo_cnt_d;
    end
  end

  // Memory requests
  assign hi_we_o    = push_hi;
  assign hi_re_o    = pop_hi;
  assign hi_waddr_o = hi_tail_q;
  assign hi_raddr_o = hi_head_q;
  assign lo_we_o    = push_lo;
  assign lo_re_o    = pop_lo;
  assign lo_waddr_o = lo_tail_q;
  assign lo_raddr_o = lo_head_q;

  // Handle resized to the stored width, zero filled above the input word
  always_comb begin
    for (int i = 0; i < int'(HANDLE_BITS); i++) begin
      wdata_o[i] = (i < int'(HandleW)) ? item_handle_i[i % HandleW] : 1'b0;
    end
  end

  // Step outcome; levels are the counts after the step, cut to the level width
  always_comb begin
    info_o           = '0;
    info_o.deq_hit   = (cmd == CmdDeq) && !(hi_empty && lo_empty);
    info_o.from_high = (cmd == CmdDeq) && !hi_empty;
    info_o.status    = deq_miss ? StatEmpty : (drop ? StatFull : StatOk);
    info_o.all_empty = (hi_cnt_d == '0) && (lo_cnt_d == '0);
    for (int i = 0; i < int'(LevelW); i++) begin
      info_o.high_level[i] = (i < int'(CntW)) ? hi_cnt_d[i % CntW] : 1'b0;
      info_o.low_level[i]  = (i < int'(CntW)) ? lo_cnt_d[i % CntW] : 1'b0;
    end
  end

endmodule

>>> rtl/two_class_priority_queue_unit.sv
// Top level of the two-class strict priority queue: control, two ring memories,
// result stage and output register. Depends on tcpq_pkg, tcpq_ctrl, tcpq_ring_mem.
//
//  channel  dir  handshake                   fields
//  -------  ---  --------------------------  ----------------------------------------------
//  cmd      in   in_valid_i / in_stall_o     command_i, item_handle_i
//  result   out  res_valid_o / res_stall_i   out_handle_o, out_valid_o, out_from_high_o,
//                                            status_o, all_empty_o, high_level_o, low_level_o
//
// One command word per cycle while in_stall_o is low; each gives one result word.
// Every command takes the same path: the registered memory read, then the output register.
// Reset clears pointers and counts at once; the handle stores are not cleared.
// A stalled result holds; input stalls only when both result stages are full and stalled.

`include "two_class_priority_queue_unit_assert.svh"

module two_class_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = tcpq_pkg::DefQueueDepth,
  parameter int unsigned HANDLE_BITS = tcpq_pkg::DefHandleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcpq_pkg::CmdW-1:0]    command_i,
  input  logic [tcpq_pkg::HandleW-1:0] item_handle_i,
  // result channel
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output logic [tcpq_pkg::HandleW-1:0] out_handle_o,
  output logic                         out_valid_o,
  output logic                         out_from_high_o,
  output logic [tcpq_pkg::StatW-1:0]   status_o,
  output logic                         all_empty_o,
  output logic [tcpq_pkg::LevelW-1:0]  high_level_o,
  output logic [tcpq_pkg::LevelW-1:0]  low_level_o
);

  import tcpq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  logic                   accept;
  logic                   hi_we, hi_re, lo_we, lo_re;
  logic [PtrW-1:0]        hi_waddr, hi_raddr, lo_waddr, lo_raddr;
  logic [HANDLE_BITS-1:0] wdata, hi_rdata, lo_rdata, sel_rdata;
  step_info_t             info;

  logic                   s1_valid_q;
  step_info_t             s1_info_q;
  logic                   s1_move;
  logic [HandleW-1:0]     s1_handle;

  logic                   res_valid_q;
  step_info_t             res_info_q;
  logic [HandleW-1:0]     res_handle_q;

  // Handshake: stage 1 drains whenever the output register is free or taken
  assign s1_move    = s1_valid_q && !(res_valid_q && res_stall_i);
  assign in_stall_o = s1_valid_q && res_valid_q && res_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  tcpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .item_handle_i (item_handle_i),
    .hi_we_o       (hi_we),
    .hi_re_o       (hi_re),
    .hi_waddr_o    (hi_waddr),
    .hi_raddr_o    (hi_raddr),
    .lo_we_o       (lo_we),
    .lo_re_o       (lo_re),
    .lo_waddr_o    (lo_waddr),
    .lo_raddr_o    (lo_raddr),
    .wdata_o       (wdata),
    .info_o        (info)
  );

  tcpq_ring_mem #(
    .Depth (QUEUE_DEPTH),
    .Width (HANDLE_BITS)
  ) u_hi_mem (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (hi_waddr),
    .wdata_i (wdata),
    .re_i    (hi_re),
    .raddr_i (hi_raddr),
    .rdata_o (hi_rdata)
  );

  tcpq_ring_mem #(
    .Depth (QUEUE_DEPTH),
    .Width (HANDLE_BITS)
  ) u_lo_mem (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (lo_waddr),
    .wdata_i (wdata),
    .re_i    (lo_re),
    .raddr_i (lo_raddr),
    .rdata_o (lo_rdata)
  );

  // Stage 1: outcome waits for the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
  end

  // Pick the ring that was read, resize to the word width, zero on a miss
  assign sel_rdata = s1_info_q.from_high ? hi_rdata : lo_rdata;

  always_comb begin
    for (int i = 0; i < int'(HandleW); i++) begin
      s1_handle[i] = (i < int'(HANDLE_BITS)) && s1_info_q.deq_hit
                     ? sel_rdata[i % HANDLE_BITS] : 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_move) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_info_q   <= s1_info_q;
      res_handle_q <= s1_handle;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign out_handle_o    = res_handle_q;
  assign out_valid_o     = res_info_q.deq_hit;
  assign out_from_high_o = res_info_q.from_high;
  assign status_o        = res_info_q.status;
  assign all_empty_o     = res_info_q.all_empty;
  assign high_level_o    = res_info_q.high_level;
  assign low_level_o     = res_info_q.low_level;

  // Checks
  `TCPQ_ASSERT_NOW(a_miss_is_empty,
    res_valid_o && (status_o == StatEmpty),
    all_empty_o && !out_valid_o && (out_handle_o == '0), "dequeue miss with data or levels")
  `TCPQ_ASSERT_NOW(a_hit_is_ok, res_valid_o && out_valid_o, status_o == StatOk,
    "dequeue hit reported with error status")
  `TCPQ_ASSERT_NOW(a_high_needs_hit, res_valid_o && out_from_high_o, out_valid_o,
    "high class flagged without a returned item")
  `TCPQ_ASSERT_NEXT(a_stall_holds_s1, in_stall_o, s1_valid_q,
    "stage 1 lost its word during an input stall")

endmodule
